### src/ssfg_pkg.sv
// Package for the shell sort block: word types, cell data type, sequencer states.
`default_nettype none
package ssfg_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned KEY_WIDTH     = 32;

   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] key_in;
      logic                        is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] key_out;
      logic                        last_out;
      logic                        overflow;
   } rsp_word_type;

   // One key slot as it moves along the cell row
   typedef struct packed {
      logic                        valid;
      logic signed [KEY_WIDTH-1:0] key;
   } cell_data_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

### src/ssfg_cell.sv
// A row cell: keeps smaller key, passes larger right; unload takes the right key.
`default_nettype none
module ssfg_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire ssfg_pkg::cell_data_type ins_data,
   input  wire ssfg_pkg::cell_data_type shl_data,
   output      ssfg_pkg::cell_data_type held_data,
   output      ssfg_pkg::cell_data_type pass_data
);
   import ssfg_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic                        pass_valid_ff, pass_valid_in;
   logic signed [KEY_WIDTH-1:0] pass_key_ff, pass_key_in;

   always_comb begin
      valid_in      = valid_ff;
      key_in        = key_ff;
      pass_valid_in = 1'b0;
      pass_key_in   = pass_key_ff;
      if (shift_en) begin
         // unload: take the neighbor's key on the right
         valid_in = shl_data.valid;
         key_in   = shl_data.key;
      end else if (ins_data.valid) begin
         if (!valid_ff) begin
            valid_in = 1'b1;
            key_in   = ins_data.key;
         end else if (ins_data.key < key_ff) begin
            key_in        = ins_data.key;
            pass_valid_in = 1'b1;
            pass_key_in   = key_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_key_in   = ins_data.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         pass_valid_ff <= pass_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      pass_key_ff <= pass_key_in;
   end

   assign held_data.valid = valid_ff;
   assign held_data.key   = key_ff;
   assign pass_data.valid = pass_valid_ff;
   assign pass_data.key   = pass_key_ff;

endmodule
`default_nettype wire

### src/shell_sort_fixed_gaps.sv
// Top level: sorts a set of signed keys in a systolic row of cells, then streams them out.
// After the word flagged last is taken, the row settles, then streams one result per cycle
//   while rsp_stall is low. Loading takes one word per cycle; a new set waits until the last
//   result leaves. The ripple of the last key through the DEPTH-cell row sets the settle time.
// Reset: synchronous, clears all cells, the fill count, the overflow flag and the sequencer.
`default_nettype none
module shell_sort_fixed_gaps #(
   parameter int unsigned DEPTH = ssfg_pkg::DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request words: one key each
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire ssfg_pkg::req_word_type req_word,
   // response words: sorted keys, ascending
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      ssfg_pkg::rsp_word_type rsp_word
);
   import ssfg_pkg::*;

   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] fill_ff, fill_in;      // keys stored, then keys left to send
   logic [CountWidth-1:0] settle_ff, settle_in;  // settle cycles left
   logic                  dropped_ff, dropped_in;

   logic          req_accept, rsp_accept, shift_en, store_ok;
   cell_data_type head_ins;
   cell_data_type held_bus [DEPTH];
   cell_data_type pass_bus [DEPTH];

   assign store_ok   = fill_ff < CountWidth'(DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // --- sequencer: next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_word.is_last) state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (settle_ff == CountWidth'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_accept && fill_ff == CountWidth'(1)) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // --- sequencer: outputs ---
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD:   req_stall = 1'b0;
         ST_SETTLE: req_stall = 1'b1;
         ST_DRAIN:  rsp_valid = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   // --- counters and overflow flag ---
   always_comb begin
      fill_in    = fill_ff;
      settle_in  = settle_ff;
      dropped_in = dropped_ff;
      if (req_accept) begin
         if (store_ok) fill_in = fill_ff + CountWidth'(1);
         else          dropped_in = 1'b1;
         settle_in = CountWidth'(DEPTH);
      end
      if (state_ff == ST_SETTLE) settle_in = settle_ff - CountWidth'(1);
      if (rsp_accept) begin
         fill_in = fill_ff - CountWidth'(1);
         if (fill_ff == CountWidth'(1)) dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         settle_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         settle_ff  <= settle_in;
         dropped_ff <= dropped_in;
      end
   end

   // --- cell row: cell 0 always holds the smallest key ---
   assign shift_en       = rsp_accept;
   assign head_ins.valid = req_accept && store_ok;
   assign head_ins.key   = req_word.key_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_data_type left_data, right_data;
      if (i == 0) begin : g_head
         assign left_data = head_ins;
      end else begin : g_body
         assign left_data = pass_bus[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = held_bus[i+1];
      end
      ssfg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .ins_data  (left_data),
         .shl_data  (right_data),
         .held_data (held_bus[i]),
         .pass_data (pass_bus[i])
      );
   end

   // response key comes straight from cell 0's register
   assign rsp_word.key_out  = held_bus[0].key;
   assign rsp_word.last_out = fill_ff == CountWidth'(1);
   assign rsp_word.overflow = dropped_ff;

   // --- checks ---
   // the row never overflows: nothing falls off the far end
   a_no_spill: assert property (@(posedge clock) disable iff (reset)
      !pass_bus[DEPTH-1].valid)
      else $error("key pushed past the last cell");

   // a response is only offered from a filled head cell
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held_bus[0].valid)
      else $error("response offered from an empty head cell");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CountWidth'(DEPTH))
      else $error("fill count beyond capacity");

   // after the final key leaves, the head cell is empty, the overflow flag is clear and loading resumes
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_word.last_out) |=> (state_ff == ST_LOAD && !held_bus[0].valid
                                             && !dropped_ff))
      else $error("row not empty after the final key");

endmodule
`default_nettype wire

### tb/tb_shell_sort_fixed_gaps.sv
// Self-checking testbench for the fixed-gap shell sort block: directed table, then random sets.
`default_nettype none
module tb_shell_sort_fixed_gaps;
   timeunit 1ns;
   timeprecision 1ps;

   import ssfg_pkg::*;

   localparam int unsigned DEPTH = DEPTH_DEFAULT;
   // Number of random items in the small sets. With the directed rows and the one big set
   // the run sends about 110 words.
   localparam int          RAND_ITEMS  = 20;
   // Long receiver hold-off, enough for the row to fill and back up into the input.
   localparam int          HOLD_CYCLES = 4 * DEPTH + 40;
   // The limit is many times the length of the slowest correct run.
   localparam int          CYCLE_LIMIT = 200000;

   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

   // One row of the directed table. When typed is set, want holds the single result of a
   // one-key set, written out by hand. Otherwise the sort model supplies the expectation.
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } stim_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int           cycle_count  = 0;
   int           error_count  = 0;
   bit           hold_request = 1'b0;
   int           tx_quiet     = 0;

   // Sorted words not yet seen on the output, oldest first
   rsp_word_type due_words[$];
   stim_row_type stim_rows[$];

   // Sort model state: keys of the set being collected
   logic signed [KEY_WIDTH-1:0] set_keys [DEPTH];
   int                          set_fill    = 0;
   logic                        set_dropped = 1'b0;

   shell_sort_fixed_gaps #(
      .DEPTH(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_shell_sort_fixed_gaps: errors");
         $finish;
      end
   end

   // Shell sort of the collected keys: gapped insertion passes with gaps 31, 15, 7, 3, 1.
   // Each gap is the previous one shifted right by one, down to 1.
   function automatic void sort_set_keys();
      int                          gap;
      int                          i;
      int                          j;
      logic signed [KEY_WIDTH-1:0] held;
      gap = 31;
      while (gap >= 1) begin
         // a gap not below the fill moves nothing, the loop just does not run
         for (i = gap; i < set_fill; i++) begin
            if (set_keys[i] < set_keys[i-gap]) begin
               held = set_keys[i];
               j    = i;
               while (j >= gap && held < set_keys[j-gap]) begin
                  set_keys[j] = set_keys[j-gap];
                  j           = j - gap;
               end
               set_keys[j] = held;
            end
         end
         gap = gap >> 1;
      end
   endfunction

   // Takes one accepted request word into the sort model. On the closing word the set is
   // sorted and, if push_due is set, its words are queued as expectations.
   function automatic void absorb_key(input req_word_type w, input bit push_due);
      rsp_word_type r;
      int           k;
      if (set_fill < DEPTH) begin
         set_keys[set_fill] = w.key_in;
         set_fill++;
      end else begin
         // set full: the key is lost, the closing key too
         set_dropped = 1'b1;
      end
      if (w.is_last) begin
         sort_set_keys();
         for (k = 0; k < set_fill; k++) begin
            r.key_out  = set_keys[k];
            r.last_out = (k == set_fill - 1);
            r.overflow = set_dropped;
            if (push_due) due_words.push_back(r);
         end
         set_fill    = 0;
         set_dropped = 1'b0;
      end
   endfunction

   function automatic logic signed [KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(0, 7))
         0: pick_key = KEY_MIN;
         1: pick_key = KEY_MAX;
         // narrow range, so equal keys turn up often
         2: pick_key = $signed($urandom_range(0, 6)) - 3;
         default: pick_key = $urandom;
      endcase
   endfunction

   function automatic void plan(input logic signed [KEY_WIDTH-1:0] key, input logic last);
      stim_row_type row;
      row             = '0;
      row.word.key_in  = key;
      row.word.is_last = last;
      stim_rows.push_back(row);
   endfunction

   // One-key set whose single result is known at a glance
   function automatic void plan_single(input logic signed [KEY_WIDTH-1:0] key);
      stim_row_type row;
      row              = '0;
      row.word.key_in  = key;
      row.word.is_last = 1'b1;
      row.typed        = 1'b1;
      row.want.key_out  = key;
      row.want.last_out = 1'b1;
      row.want.overflow = 1'b0;
      stim_rows.push_back(row);
   endfunction

   // Offers one request word after a random gap and returns at the edge that takes it.
   // Called at a rising edge; valid stays high across back-to-back words.
   task automatic send_word(input req_word_type w);
      int gap;
      if (tx_quiet > 0) begin
         tx_quiet--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 15) == 0) tx_quiet = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic send_set(input int size);
      req_word_type w;
      int           k;
      for (k = 0; k < size; k++) begin
         w.key_in  = pick_key();
         w.is_last = (k == size - 1);
         send_word(w);
         absorb_key(w, 1'b1);
      end
   endtask

   // Receiver: random stalls per word, one long hold-off on request, checks every word
   initial begin
      rsp_word_type want;
      int           gap;
      int           rx_quiet;
      rx_quiet = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap          = HOLD_CYCLES;
         end else if (rx_quiet > 0) begin
            rx_quiet--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) rx_quiet = $urandom_range(8, 30);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         // stall was low before this edge, so the word is taken here
         if (due_words.size() == 0) begin
            error_count++;
            $error("unexpected word: key_out=%0d last_out=%0b overflow=%0b",
                   rsp_word.key_out, rsp_word.last_out, rsp_word.overflow);
         end else begin
            want = due_words.pop_front();
            if (rsp_word.key_out !== want.key_out) begin
               error_count++;
               $error("key_out: expected %0d, got %0d", want.key_out, rsp_word.key_out);
            end
            if (rsp_word.last_out !== want.last_out) begin
               error_count++;
               $error("last_out: expected %0b, got %0b", want.last_out, rsp_word.last_out);
            end
            if (rsp_word.overflow !== want.overflow) begin
               error_count++;
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_word.overflow);
            end
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type row;
      int           rand_sent;
      int           size;

      // extremes of the key, zero and minus one, each as a one-key set
      plan_single(KEY_MIN);
      plan_single(KEY_MAX);
      plan_single('0);
      plan_single(-1);
      // two keys at opposite extremes, arriving in reverse order
      plan(KEY_MAX, 1'b0);
      plan(KEY_MIN, 1'b1);
      // equal keys
      plan(5, 1'b0);
      plan(5, 1'b0);
      plan(5, 1'b1);
      // strictly descending set
      plan(32'sh4000_0000, 1'b0);
      plan(1000, 1'b0);
      plan(7, 1'b0);
      plan(1, 1'b0);
      plan(0, 1'b0);
      plan(-1, 1'b0);
      plan(-1000, 1'b0);
      plan(32'shC000_0000, 1'b1);
      // mixed signs, alternating bit patterns, neighbors of the extremes
      plan(32'sh5555_5555, 1'b0);
      plan(32'shAAAA_AAAA, 1'b0);
      plan(32'sh8000_0001, 1'b0);
      plan(32'sh7FFF_FFFE, 1'b0);
      plan(0, 1'b0);
      plan(1, 1'b0);
      plan(-2, 1'b0);
      plan(32'sh0001_0000, 1'b1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         send_word(row.word);
         absorb_key(row.word, !row.typed);
         if (row.typed) due_words.push_back(row.want);
      end

      // Receiver holds off while the big set is offered, so it backs up at the input
      hold_request = 1'b1;
      // overflow: the row fills exactly, the closing key is the one dropped
      send_set(DEPTH + 1);

      // small sets; the first one also shows the overflow flag cleared again
      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         size = $urandom_range(1, 8);
         send_set(size);
         rand_sent += size;
      end
      req_valid <= 1'b0;

      while (due_words.size() != 0) @(posedge clock);
      // settle time of the row plus margin, to catch stray words
      repeat (2 * DEPTH + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_shell_sort_fixed_gaps: clean");
      end else begin
         $display("tb_shell_sort_fixed_gaps: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
